// ===== rtl/core/command_frame_deframer_top_macros.svh =====
// Assertion macros for the command frame deframer.
`ifndef COMMAND_FRAME_DEFRAMER_TOP_MACROS_SVH
`define COMMAND_FRAME_DEFRAMER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define CFD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define CFD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CFD_ASSERT_IMP(lbl, ante, cons, msg)

`define CFD_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/core/cfd_pkg.sv =====
// Types and constants of the command frame deframer.
package cfd_pkg;

    localparam logic [7:0] START_MARK       = 8'hA5;
    localparam int         MAX_LIBS         = 16;
    localparam int         PAYLOAD_CAPACITY = 64;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 3;
    localparam int LIBS_W     = 5;

    typedef enum logic [4:0] {
        PH_HUNT   = 5'b00001,
        PH_TARGET = 5'b00010,
        PH_CMD    = 5'b00100,
        PH_SIZE   = 5'b01000,
        PH_DATA   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0] target_lib;
        logic [7:0] command_code;
        logic [7:0] declared_len;
        logic       has_payload;
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
        logic       last;
        logic       target_ok;
        logic       beyond_capacity;
    } result_t;

endpackage

// ===== rtl/core/command_frame_deframer_top.sv =====
// Top level of the command frame deframer: header parser and output skid stage.
//
// Usage:
//   s_tdata carries one received byte per beat. Bytes other than 0xA5 are
//   dropped while hunting; after the mark come target library, command and
//   size bytes, then size payload bytes. Each payload beat gives one result
//   beat on m_*; a size of zero gives one header-only result at once, with
//   m_tuser has_payload low. m_tlast marks the beat that ends a message.
//   cfg_wr_en/cfg_wr_data load the registered library count; write it only
//   while the block is idle.
// Timing:
//   One byte per cycle while s_tready is high; each result is registered.
//   The parser is a single registered stage; a two-entry output (result
//   register plus skid register) keeps s_tready registered.
// Stall:
//   While m_tready is low, results collect in the skid register; s_tready
//   drops once it is full and rises again when the receiver takes a beat.
// Reset:
//   rst_n clears the parser to hunting, the held header to zero, the library
//   count to zero and empties both output entries.
`include "command_frame_deframer_top_macros.svh"

module command_frame_deframer_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [cfd_pkg::LIBS_W-1:0]         cfg_wr_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [cfd_pkg::IN_DATA_W-1:0]      s_tdata,   // [7:0] rx_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] target_lib, [15:8] command_code, [23:16] declared_len,
    // [31:24] payload_byte, [39:32] byte_index
    output logic [cfd_pkg::OUT_DATA_W-1:0]     m_tdata,
    // [0] has_payload, [1] target_ok, [2] beyond_capacity
    output logic [cfd_pkg::OUT_USER_W-1:0]     m_tuser,
    output logic                               m_tlast
);

    cfd_pkg::phase_t             phase_reg, phase_next;
    logic [7:0]                  target_reg, target_next;
    logic [7:0]                  command_reg, command_next;
    logic [7:0]                  size_reg, size_next;
    logic [7:0]                  seen_reg, seen_next;
    logic [cfd_pkg::LIBS_W-1:0]  libs_reg;

    cfd_pkg::result_t            out_reg, skid_reg, res;
    logic                        out_valid_reg, skid_valid_reg;
    logic                        push, pop, accept;
    logic                        target_ok;
    logic [8:0]                  idx_plus;
    logic                        data_last;

    localparam logic [7:0] MaxLibs  = 8'(cfd_pkg::MAX_LIBS);
    localparam logic [8:0] Capacity = 9'(cfd_pkg::PAYLOAD_CAPACITY);

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;

    assign target_ok = (target_reg < MaxLibs) && ({3'b000, libs_reg} > target_reg);
    assign idx_plus  = {1'b0, seen_reg} + 9'd1;
    assign data_last = idx_plus >= {1'b0, size_reg};

    always_comb
    begin
        phase_next   = phase_reg;
        target_next  = target_reg;
        command_next = command_reg;
        size_next    = size_reg;
        seen_next    = seen_reg;
        push         = 1'b0;
        res.target_lib      = target_reg;
        res.command_code    = command_reg;
        res.declared_len    = size_reg;
        res.has_payload     = 1'b1;
        res.payload_byte    = s_tdata;
        res.byte_index      = seen_reg;
        res.last            = data_last;
        res.target_ok       = target_ok;
        res.beyond_capacity = {1'b0, seen_reg} >= Capacity;
        if (accept)
        begin
            unique case (phase_reg)
                cfd_pkg::PH_HUNT:
                begin
                    if (s_tdata == cfd_pkg::START_MARK)
                    begin
                        phase_next = cfd_pkg::PH_TARGET;
                    end
                end
                cfd_pkg::PH_TARGET:
                begin
                    target_next = s_tdata;
                    phase_next  = cfd_pkg::PH_CMD;
                end
                cfd_pkg::PH_CMD:
                begin
                    command_next = s_tdata;
                    phase_next   = cfd_pkg::PH_SIZE;
                end
                cfd_pkg::PH_SIZE:
                begin
                    size_next = s_tdata;
                    seen_next = 8'd0;
                    if (s_tdata == 8'd0)
                    begin
                        phase_next          = cfd_pkg::PH_HUNT;
                        push                = 1'b1;
                        res.declared_len    = 8'd0;
                        res.has_payload     = 1'b0;
                        res.payload_byte    = 8'd0;
                        res.byte_index      = 8'd0;
                        res.last            = 1'b1;
                        res.beyond_capacity = 1'b0;
                    end
                    else
                    begin
                        phase_next = cfd_pkg::PH_DATA;
                    end
                end
                cfd_pkg::PH_DATA:
                begin
                    push      = 1'b1;
                    seen_next = idx_plus[7:0];
                    if (data_last)
                    begin
                        phase_next = cfd_pkg::PH_HUNT;
                    end
                end
                default:
                begin
                    phase_next = cfd_pkg::PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= cfd_pkg::PH_HUNT;
            target_reg  <= 8'd0;
            command_reg <= 8'd0;
            size_reg    <= 8'd0;
            seen_reg    <= 8'd0;
            libs_reg    <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            target_reg  <= target_next;
            command_reg <= command_next;
            size_reg    <= size_next;
            seen_reg    <= seen_next;
            if (cfg_wr_en)
            begin
                libs_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_reg <= res;
            end
            else
            begin
                skid_reg <= res;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.byte_index, out_reg.payload_byte, out_reg.declared_len,
                       out_reg.command_code, out_reg.target_lib};
    assign m_tuser  = {out_reg.beyond_capacity, out_reg.target_ok, out_reg.has_payload};
    assign m_tlast  = out_reg.last;

    `CFD_ASSERT_IMP(a_skid_needs_out, skid_valid_reg, out_valid_reg,
        "skid entry held while output register empty")
    `CFD_ASSERT_IMP(a_empty_msg_shape, m_tvalid && !m_tuser[0],
        m_tlast && (m_tdata[39:24] == 16'd0) && !m_tuser[2],
        "header-only result with payload fields set")
    `CFD_ASSERT_IMP(a_data_size_nonzero, phase_reg == cfd_pkg::PH_DATA, size_reg != 8'd0,
        "payload phase with zero declared size")
    `CFD_ASSERT_NXT(a_last_returns_hunt, accept && push && res.last,
        phase_reg == cfd_pkg::PH_HUNT, "parser not hunting after message end")

endmodule
